// ----- design/api_tx_request_framer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the API transmit-request framer
// ---------------------------------------------------------------------------
`ifndef API_TX_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define API_TX_REQUEST_FRAMER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define APTXF_ASSERT_RUN(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

// Checked on every edge, reset included.
`define APTXF_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("framer reset check failed");

`endif

// ----- design/aptxf_pkg.sv -----
// ---------------------------------------------------------------------------
// aptxf_pkg
// Widths, header constants and sequencer positions of the TX request framer.
// ---------------------------------------------------------------------------
`default_nettype none

package aptxf_pkg;

    localparam int FRAME_BUFFER_BYTES = 128;
    localparam int HDR_CHK_BYTES      = 18;
    localparam int CAP_RAW            = FRAME_BUFFER_BYTES - HDR_CHK_BYTES;
    localparam int PAYLOAD_CAP_INT    = (CAP_RAW < 127) ? CAP_RAW : 127;

    localparam int LEN_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int DEST_W     = 64;
    localparam int NET_W      = 16;
    localparam int POS_W      = 5;

    localparam logic [LEN_W-1:0]  PAYLOAD_CAP    = LEN_W'(PAYLOAD_CAP_INT);
    localparam logic [15:0]       LEN_OVERHEAD   = 16'd14;
    localparam logic [BYTE_W-1:0] START_BYTE     = 8'h7E;
    localparam logic [BYTE_W-1:0] TX_REQ_TYPE    = 8'h10;
    localparam logic [BYTE_W-1:0] RADIUS_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] CHECKSUM_BASE  = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_ADDR  = 1'b1;

    // tuser bit positions on the input side
    localparam int USER_FRAME_START = 0;
    localparam int USER_CRITICAL    = 1;

    // byte positions within the result sequence of one item
    localparam logic [POS_W-1:0] POS_START      = 5'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 5'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 5'd2;
    localparam logic [POS_W-1:0] POS_TYPE       = 5'd3;
    localparam logic [POS_W-1:0] POS_FRAME_ID   = 5'd4;
    localparam logic [POS_W-1:0] POS_DEST_FIRST = 5'd5;
    localparam logic [POS_W-1:0] POS_DEST_LAST  = 5'd12;
    localparam logic [POS_W-1:0] POS_NET_HI     = 5'd13;
    localparam logic [POS_W-1:0] POS_NET_LO     = 5'd14;
    localparam logic [POS_W-1:0] POS_RADIUS     = 5'd15;
    localparam logic [POS_W-1:0] POS_OPTIONS    = 5'd16;
    localparam logic [POS_W-1:0] POS_BODY       = 5'd17;
    localparam logic [POS_W-1:0] POS_CHECK      = 5'd18;

endpackage

`default_nettype wire

// ----- design/api_tx_request_framer_unit.sv -----
// ---------------------------------------------------------------------------
// api_tx_request_framer_unit
// Serializes transmit-request API frames (type 0x10), one byte per handshake.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: tdata = payload byte, payload_length,
//   tuser = frame_start, critical. A frame start item produces the 17 header
//   bytes, then its first payload byte (or the checksum for an empty frame).
//   Each later payload item produces its byte, and the last one also the
//   checksum. m_axis delivers one frame byte per handshake; tlast marks the
//   checksum byte. Items of no open frame are dropped without output.
//   An accepted item is held in the item register; its bytes reach m_axis
//   through the output register.
//   The single output register gives one output byte per cycle while m_axis
//   is not stalled; a start item yields 18 or 19 bytes, a payload item 1 or 2.
//   A new item is taken in the cycle the previous item's last byte loads.
//   A stall on m_axis holds the output byte and, once the item in flight has
//   no place for its next byte, deasserts s_axis_tready.
//   Configuration writes (destination addresses) are always accepted.
//   Reset clears the open frame, the checksum and both address registers.
// ---------------------------------------------------------------------------
`default_nettype none

module api_tx_request_framer_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: [7:0] payload byte, [14:8] payload_length, [15] zero
    input  wire logic [aptxf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: [0] frame_start, [1] critical
    input  wire logic [aptxf_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: [7:0] tx_byte
    output logic [aptxf_pkg::BYTE_W-1:0]             m_axis_tdata,
    output logic                                     m_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [aptxf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [aptxf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration
    logic [aptxf_pkg::DEST_W-1:0] r_dest;
    logic [aptxf_pkg::NET_W-1:0]  r_net;

    // item register
    logic                         r_busy;
    logic                         r_start;
    logic                         r_crit;
    logic [aptxf_pkg::BYTE_W-1:0] r_data;
    logic [aptxf_pkg::LEN_W-1:0]  r_len;
    logic [aptxf_pkg::POS_W-1:0]  r_pos;

    // frame state
    logic                         r_active;
    logic [aptxf_pkg::LEN_W-1:0]  r_left;
    logic [aptxf_pkg::BYTE_W-1:0] r_sum;

    // output register
    logic                         r_out_valid;
    logic                         r_out_last;
    logic [aptxf_pkg::BYTE_W-1:0] r_out_data;

    logic                         cfg_fire;
    logic                         in_fire;
    logic                         drop;
    logic                         out_load;
    logic                         item_done;
    logic [aptxf_pkg::LEN_W-1:0]  in_len;
    logic [aptxf_pkg::LEN_W-1:0]  in_len_cap;
    logic [15:0]                  total_len;
    logic [2:0]                   dest_idx;
    logic [aptxf_pkg::BYTE_W-1:0] chk_byte;
    logic [aptxf_pkg::BYTE_W-1:0] cur_byte;
    logic                         cur_sum;
    logic                         cur_data;
    logic                         cur_chk;
    logic                         cur_last;

    assign o_cfg_ready   = 1'b1;
    assign cfg_fire      = i_cfg_valid && o_cfg_ready;

    assign in_len        = s_axis_tdata[aptxf_pkg::BYTE_W +: aptxf_pkg::LEN_W];
    assign in_len_cap    = (in_len > aptxf_pkg::PAYLOAD_CAP) ? aptxf_pkg::PAYLOAD_CAP : in_len;

    // payload item with no open frame: discarded without output
    assign drop          = r_busy && !r_start && !r_active;
    assign out_load      = r_busy && !drop && (!r_out_valid || m_axis_tready);
    assign item_done     = drop || (out_load && cur_last);
    assign s_axis_tready = !r_busy || item_done;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign total_len     = aptxf_pkg::LEN_OVERHEAD + 16'(r_len);
    assign dest_idx      = 3'(aptxf_pkg::POS_DEST_LAST - r_pos);
    assign chk_byte      = aptxf_pkg::CHECKSUM_BASE - r_sum;

    always_comb begin
        cur_byte = '0;
        cur_sum  = 1'b0;
        cur_data = 1'b0;
        cur_chk  = 1'b0;
        cur_last = 1'b0;
        unique case (r_pos) inside
            aptxf_pkg::POS_START:    cur_byte = aptxf_pkg::START_BYTE;
            aptxf_pkg::POS_LEN_HI:   cur_byte = total_len[15:8];
            aptxf_pkg::POS_LEN_LO:   cur_byte = total_len[7:0];
            aptxf_pkg::POS_TYPE: begin
                cur_byte = aptxf_pkg::TX_REQ_TYPE;
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_FRAME_ID: begin
                cur_byte = {7'd0, r_crit};
                cur_sum  = 1'b1;
            end
            [aptxf_pkg::POS_DEST_FIRST:aptxf_pkg::POS_DEST_LAST]: begin
                cur_byte = r_dest[{dest_idx, 3'b000} +: aptxf_pkg::BYTE_W];
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_NET_HI: begin
                cur_byte = r_net[15:8];
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_NET_LO: begin
                cur_byte = r_net[7:0];
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_RADIUS: begin
                cur_byte = aptxf_pkg::RADIUS_BYTE;
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_OPTIONS: begin
                cur_byte = {7'd0, !r_crit};
                cur_sum  = 1'b1;
            end
            aptxf_pkg::POS_BODY: begin
                if (r_left != '0) begin
                    cur_byte = r_data;
                    cur_sum  = 1'b1;
                    cur_data = 1'b1;
                    // last payload byte is followed by the checksum
                    cur_last = (r_left != aptxf_pkg::LEN_W'(1));
                end else begin
                    cur_byte = chk_byte;
                    cur_chk  = 1'b1;
                    cur_last = 1'b1;
                end
            end
            aptxf_pkg::POS_CHECK: begin
                cur_byte = chk_byte;
                cur_chk  = 1'b1;
                cur_last = 1'b1;
            end
            default: cur_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest      <= '0;
            r_net       <= '0;
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_left      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (i_cfg_index)
                    aptxf_pkg::CFG_DEST_ADDR: r_dest <= i_cfg_data;
                    aptxf_pkg::CFG_NET_ADDR:  r_net  <= i_cfg_data[aptxf_pkg::NET_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (out_load) begin
                if (r_pos == aptxf_pkg::POS_START) begin
                    r_active <= 1'b1;
                    r_left   <= r_len;
                    r_sum    <= '0;
                end else if (cur_chk) begin
                    r_active <= 1'b0;
                    r_left   <= '0;
                    r_sum    <= '0;
                end else if (cur_sum) begin
                    r_sum <= r_sum + cur_byte;
                    if (cur_data) begin
                        r_left <= r_left - aptxf_pkg::LEN_W'(1);
                    end
                end
            end

            if (in_fire) begin
                r_busy <= 1'b1;
                r_pos  <= s_axis_tuser[aptxf_pkg::USER_FRAME_START] ?
                          aptxf_pkg::POS_START : aptxf_pkg::POS_BODY;
            end else begin
                if (item_done) begin
                    r_busy <= 1'b0;
                end
                if (out_load) begin
                    r_pos <= r_pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data  <= s_axis_tdata[aptxf_pkg::BYTE_W-1:0];
            r_len   <= in_len_cap;
            r_start <= s_axis_tuser[aptxf_pkg::USER_FRAME_START];
            r_crit  <= s_axis_tuser[aptxf_pkg::USER_CRITICAL];
        end
        if (out_load) begin
            r_out_data <= cur_byte;
            r_out_last <= cur_chk;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- design/aptxf_checker.sv -----
// ---------------------------------------------------------------------------
// aptxf_checker
// Port-level checks on the TX request framer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "api_tx_request_framer_unit_assert.svh"

module aptxf_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [aptxf_pkg::IN_USER_W-1:0]     s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic [aptxf_pkg::BYTE_W-1:0]        m_axis_tdata,
    input  wire logic                                m_axis_tlast,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready
);

    logic s_fire;
    logic m_fire;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign m_fire   = m_axis_tvalid && m_axis_tready;

    // output register is empty right after reset
    `APTXF_ASSERT_ALWAYS(a_rst_out_empty, !i_rst_n, !m_axis_tvalid)

    // a stalled byte holds
    `APTXF_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // the header burst keeps the input closed in the cycle after a start item
    `APTXF_ASSERT_RUN(a_start_busy, s_fire && s_axis_tuser[aptxf_pkg::USER_FRAME_START],
        !s_axis_tready)

    // a checksum byte is never directly followed by another one
    `APTXF_ASSERT_RUN(a_no_double_eof, m_fire && m_axis_tlast,
        !(m_axis_tvalid && m_axis_tlast))

endmodule

bind api_tx_request_framer_unit aptxf_checker u_aptxf_checker (.*);

`default_nettype wire
